>>> rtl/rra_pkg.sv
// ============================================================================
// rra_pkg: shared types and codes of the round-robin ID allocator
// Command, answer and entry codes, and the control group fed to each cell.
// ============================================================================
package rra_pkg;

  // Command codes of an input beat
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_FINISH  = 2'd3
  } cmd_e;

  // Answer codes of an output beat
  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_FULL   = 2'd1,
    RES_RANGE  = 2'd2,
    RES_NOINIT = 2'd3
  } res_e;

  // Per-entry status held in each cell
  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_INUSE    = 2'd1,
    ST_RELEASED = 2'd2
  } entry_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic init;    // clear entry to free
    logic finish;  // released -> free
    logic rel_en;  // release the entry whose index matches
    logic start;   // drop the search token at the start index
    logic step;    // search cycle: claim if holding token and free, pass token on
  } ctrl_t;

  localparam int unsigned IdW = 16;

endpackage

>>> rtl/rra_cell.sv
// ============================================================================
// rra_cell: one entry of the allocator ring
// Holds the entry status and the search token; claims the entry when the
// token sits here and the entry is free, and hands the token to its neighbor.
// ============================================================================
module rra_cell #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rra_pkg::ctrl_t   ctrl_i,
  input  logic [IdxW-1:0]  rel_idx_i,
  input  logic [IdxW-1:0]  start_idx_i,
  input  logic             token_i,
  output logic             token_o,
  output logic             hit_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  rra_pkg::entry_e status_q, status_d;
  logic            token_q, token_d;

  // token here and entry free during a search cycle
  assign hit_o   = ctrl_i.step && token_q && (status_q == rra_pkg::ST_FREE);
  assign token_o = token_q;

  // token movement: load at start, shift one cell per search cycle
  always_comb begin
    token_d = token_q;
    if (ctrl_i.start) begin
      token_d = (start_idx_i == MyIdx);
    end else if (ctrl_i.step) begin
      token_d = token_i;
    end
  end

  // entry status update
  always_comb begin
    status_d = status_q;
    if (ctrl_i.init) begin
      status_d = rra_pkg::ST_FREE;
    end else if (ctrl_i.finish) begin
      if (status_q == rra_pkg::ST_RELEASED) status_d = rra_pkg::ST_FREE;
    end else if (ctrl_i.rel_en && (rel_idx_i == MyIdx)) begin
      status_d = rra_pkg::ST_RELEASED;
    end else if (hit_o) begin
      status_d = rra_pkg::ST_INUSE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= rra_pkg::ST_FREE;
      token_q  <= 1'b0;
    end else begin
      status_q <= status_d;
      token_q  <= token_d;
    end
  end

endmodule

>>> rtl/round_robin_id_allocator.sv
// ============================================================================
// round_robin_id_allocator: round-robin free-list ID allocator
// A ring of NUM_IDS cells holds the entry status; a one-hot search token
// walks the ring from the search pointer to find a free entry.
// ============================================================================
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i/in_ready_o, command_i,| in
//          | release_id_i                     |
//  out     | out_valid_o/out_ready_i,         | out
//          | new_id_o, status_o               |
//
// For init, release and finish the result is valid the cycle after accept,
// and the next beat is taken the cycle after it leaves.
// Allocate adds a search: the token steps one cell per cycle around the ring,
// visiting 1..NUM_IDS cells until it claims a free entry or finds none.
// One beat is in flight at a time; a new beat is taken once the result leaves.
// Reset clears all entries to free, the pointer to 0 and the init flag.
// A stalled output holds its result and keeps the input blocked until it leaves.
// ============================================================================
module round_robin_id_allocator #(
  parameter int unsigned NUM_IDS = 64,
  parameter int unsigned ID_BASE = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] release_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] new_id_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IdxW = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_IDS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESP
  } state_e;

  state_e            state_q;
  logic              init_q;
  logic [IdxW-1:0]   ptr_q;
  logic [IdxW-1:0]   pos_q;
  logic [IdxW-1:0]   cnt_q;
  logic [15:0]       new_id_q;
  rra_pkg::res_e     status_q;

  rra_pkg::ctrl_t    ctrl;
  rra_pkg::cmd_e     cmd;
  logic              accept;
  logic [16:0]       rel_off;
  logic              rel_ok;
  logic [IdxW-1:0]   rel_idx;
  logic [IdxW-1:0]   pos_next;
  logic [NUM_IDS-1:0] tok;
  logic [NUM_IDS-1:0] hit;
  logic              hit_any;

  assign cmd    = rra_pkg::cmd_e'(command_i);
  assign accept = in_valid_i && in_ready_o;

  // release range check
  assign rel_off = {1'b0, release_id_i} - 17'(ID_BASE);
  assign rel_ok  = (release_id_i >= 16'(ID_BASE)) && (rel_off < 17'(NUM_IDS));
  assign rel_idx = rel_off[IdxW-1:0];

  assign pos_next = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;

  // broadcast control to the ring
  always_comb begin
    ctrl        = '0;
    ctrl.init   = accept && (cmd == rra_pkg::CMD_INIT);
    ctrl.finish = accept && (cmd == rra_pkg::CMD_FINISH);
    ctrl.rel_en = accept && (cmd == rra_pkg::CMD_RELEASE) && init_q && rel_ok;
    ctrl.start  = accept && (cmd == rra_pkg::CMD_ALLOC) && init_q;
    ctrl.step   = (state_q == S_SEARCH);
  end

  // ring of cells, token passes from cell i-1 to cell i
  for (genvar g = 0; g < NUM_IDS; g++) begin : g_cell
    rra_cell #(
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .rel_idx_i   (rel_idx),
      .start_idx_i (ptr_q),
      .token_i     (tok[(g + NUM_IDS - 1) % NUM_IDS]),
      .token_o     (tok[g]),
      .hit_o       (hit[g])
    );
  end

  assign hit_any = |hit;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      init_q   <= 1'b0;
      ptr_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      new_id_q <= '0;
      status_q <= rra_pkg::RES_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            new_id_q <= '0;
            status_q <= rra_pkg::RES_OK;
            state_q  <= S_RESP;
            unique case (cmd)
              rra_pkg::CMD_INIT: begin
                init_q <= 1'b1;
                ptr_q  <= '0;
              end
              rra_pkg::CMD_ALLOC: begin
                if (!init_q) begin
                  status_q <= rra_pkg::RES_NOINIT;
                end else begin
                  pos_q   <= ptr_q;
                  cnt_q   <= '0;
                  state_q <= S_SEARCH;
                end
              end
              rra_pkg::CMD_RELEASE: begin
                if (!init_q) status_q <= rra_pkg::RES_NOINIT;
                else if (!rel_ok) status_q <= rra_pkg::RES_RANGE;
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit_any) begin
            new_id_q <= 16'(pos_q) + 16'(ID_BASE);
            ptr_q    <= pos_next;
            state_q  <= S_RESP;
          end else if (cnt_q == LastIdx) begin
            status_q <= rra_pkg::RES_FULL;
            state_q  <= S_RESP;
          end else begin
            pos_q <= pos_next;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RESP: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign new_id_o    = new_id_q;
  assign status_o    = status_q;

  // at most one cell claims per search cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit))
    else $error("more than one cell hit");

  // exactly one token circulates while searching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> $onehot(tok))
    else $error("search token lost or duplicated");

  // the token position tracks the cell that reports the hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> tok[pos_q])
    else $error("token not at tracked position");

  // a hit ends the search with an ok answer and a nonzero ID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && hit_any) |=>
      (state_q == S_RESP && status_q == rra_pkg::RES_OK && new_id_q != '0))
    else $error("hit did not give an ID");

  // once initialized, the block stays initialized
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(init_q))
    else $error("init flag dropped");

endmodule

>>> dv/tb_round_robin_id_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_round_robin_id_allocator: self-checking bench for the ID allocator
// Drives command beats through the valid/ready input channel, keeps its own
// table of entry states, search pointer and init flag, and checks every
// answer beat (new_id, status) in order against the predicted one.
// ============================================================================
module tb_round_robin_id_allocator;

  localparam int unsigned NUM_IDS      = 64;
  localparam int unsigned ID_BASE      = 1;
  localparam int unsigned RANDOM_BEATS = 1050;
  localparam int unsigned IDLE_LIMIT   = 2000;

  // One predicted answer beat
  typedef struct packed {
    logic [rra_pkg::IdW-1:0] id;
    rra_pkg::res_e           status;
  } answer_t;

  // Tracks the allocator's table and compares answer beats in order
  class id_ledger;
    rra_pkg::entry_e entries[NUM_IDS];
    int unsigned     search_ptr;
    bit              is_init;
    answer_t         pending_answers[$];
    int unsigned     mismatch_cnt;

    function new();
      foreach (entries[i]) entries[i] = rra_pkg::ST_FREE;
      search_ptr   = 0;
      is_init      = 1'b0;
      mismatch_cnt = 0;
    endfunction

    function int unsigned outstanding();
      return pending_answers.size();
    endfunction

    // Random ID that is currently handed out, or any in-range ID if none is
    function logic [15:0] pick_held_id();
      int unsigned held[$];
      foreach (entries[i]) if (entries[i] == rra_pkg::ST_INUSE) held.push_back(i);
      if (held.size() == 0) return 16'(ID_BASE + $urandom_range(0, NUM_IDS - 1));
      return 16'(ID_BASE + held[$urandom_range(0, held.size() - 1)]);
    endfunction

    // Apply one accepted command beat and queue the answer it must produce
    function void note_command(rra_pkg::cmd_e cmd, logic [15:0] rid);
      answer_t     ans;
      int unsigned pos;
      bit          found;
      ans.id     = '0;
      ans.status = rra_pkg::RES_OK;
      found      = 1'b0;
      pos        = search_ptr;
      case (cmd)
        rra_pkg::CMD_INIT: begin
          foreach (entries[i]) entries[i] = rra_pkg::ST_FREE;
          search_ptr = 0;
          is_init    = 1'b1;
        end
        rra_pkg::CMD_ALLOC: begin
          if (!is_init) begin
            ans.status = rra_pkg::RES_NOINIT;
          end else begin
            // walk the ring from the pointer, stop on the first free entry
            for (int n = 0; n < NUM_IDS && !found; n++) begin
              if (entries[pos] == rra_pkg::ST_FREE) found = 1'b1;
              else pos = (pos + 1) % NUM_IDS;
            end
            if (found) begin
              entries[pos] = rra_pkg::ST_INUSE;
              ans.id       = 16'(pos + ID_BASE);
              search_ptr   = (pos + 1) % NUM_IDS;
            end else begin
              ans.status = rra_pkg::RES_FULL;
            end
          end
        end
        rra_pkg::CMD_RELEASE: begin
          if (!is_init) ans.status = rra_pkg::RES_NOINIT;
          else if (rid < ID_BASE || rid - ID_BASE >= NUM_IDS)
            ans.status = rra_pkg::RES_RANGE;
          else entries[rid - ID_BASE] = rra_pkg::ST_RELEASED;
        end
        default: begin
          // finish cycle: released entries go back to free
          foreach (entries[i])
            if (entries[i] == rra_pkg::ST_RELEASED) entries[i] = rra_pkg::ST_FREE;
        end
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void flag(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Compare one answer beat with the oldest prediction
    function void check_answer(logic [15:0] id, logic [1:0] status);
      answer_t exp_ans;
      if (pending_answers.size() == 0) begin
        flag($sformatf("unexpected beat new_id=%0d status=%0d", id, status));
        return;
      end
      exp_ans = pending_answers.pop_front();
      if (id !== exp_ans.id)
        flag($sformatf("new_id expected %0d actual %0d", exp_ans.id, id));
      if (status !== exp_ans.status)
        flag($sformatf("status expected %0d actual %0d", exp_ans.status, status));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command     = rra_pkg::CMD_INIT;
  logic [15:0] release_id  = '0;
  logic        out_valid_o;
  logic        out_ready   = 1'b0;
  logic [15:0] new_id_o;
  logic [1:0]  status_o;

  id_ledger    ledger = new();
  int unsigned burst_left = 5;
  int unsigned idle_cycles = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_phase = 0;

  round_robin_id_allocator #(
    .NUM_IDS (NUM_IDS),
    .ID_BASE (ID_BASE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (command),
    .release_id_i (release_id),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .new_id_o     (new_id_o),
    .status_o     (status_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: switches between always ready, coin flip, long stalls, periodic
  always @(posedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_phase <= $urandom_range(20, 200);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (rx_phase[2:0] != 3'd0);
    endcase
  end

  // Answer beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) ledger.check_answer(new_id_o, status_o);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one command beat and hold it until accepted
  task automatic send_beat(rra_pkg::cmd_e cmd, logic [15:0] rid);
    in_valid   <= 1'b1;
    command    <= cmd;
    release_id <= rid;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_command(cmd, rid);
  endtask

  // Send a beat, then keep valid up or open a gap at the end of a burst
  task automatic issue(rra_pkg::cmd_e cmd, logic [15:0] rid);
    send_beat(cmd, rid);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every answer has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (ledger.outstanding() != 0);
  endtask

  initial begin
    int unsigned   sent;
    int unsigned   mode;
    int unsigned   len;
    int unsigned   r;
    bit            paused;
    rra_pkg::cmd_e cmd;
    logic [15:0]   rid;

    sent   = 0;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: before init, range edges, release of free/released, reuse timing
    issue(rra_pkg::CMD_ALLOC,   16'h0000);
    issue(rra_pkg::CMD_RELEASE, 16'h0001);
    issue(rra_pkg::CMD_RELEASE, 16'hFFFF);
    issue(rra_pkg::CMD_FINISH,  16'h0000);
    issue(rra_pkg::CMD_INIT,    16'hFFFF);
    issue(rra_pkg::CMD_RELEASE, 16'h0000);
    issue(rra_pkg::CMD_RELEASE, 16'(ID_BASE + NUM_IDS));
    issue(rra_pkg::CMD_RELEASE, 16'hFFFF);
    issue(rra_pkg::CMD_RELEASE, 16'(ID_BASE + NUM_IDS - 1));
    issue(rra_pkg::CMD_RELEASE, 16'(ID_BASE));
    issue(rra_pkg::CMD_ALLOC,   16'h0000);
    issue(rra_pkg::CMD_FINISH,  16'h0000);
    issue(rra_pkg::CMD_ALLOC,   16'h0000);
    issue(rra_pkg::CMD_RELEASE, 16'(ID_BASE + 1));
    issue(rra_pkg::CMD_RELEASE, 16'(ID_BASE + 1));
    issue(rra_pkg::CMD_ALLOC,   16'h0000);
    issue(rra_pkg::CMD_FINISH,  16'h0000);
    issue(rra_pkg::CMD_INIT,    16'h0000);
    issue(rra_pkg::CMD_ALLOC,   16'h0000);
    issue(rra_pkg::CMD_RELEASE, 16'hAAAA);
    issue(rra_pkg::CMD_RELEASE, 16'h5555);

    // random episodes: init, fill, churn, drain and noise
    while (sent < RANDOM_BEATS) begin
      mode = $urandom_range(0, 19);
      len  = (mode == 0) ? 1 : $urandom_range(8, 70);
      for (int k = 0; k < len; k++) begin
        r   = $urandom_range(0, 99);
        rid = 16'($urandom);
        if (mode == 0) begin
          cmd = rra_pkg::CMD_INIT;
        end else if (mode <= 8) begin
          if (r < 85) cmd = rra_pkg::CMD_ALLOC;
          else if (r < 95) begin
            cmd = rra_pkg::CMD_RELEASE;
            rid = ledger.pick_held_id();
          end else cmd = rra_pkg::CMD_FINISH;
        end else if (mode <= 14) begin
          if (r < 40) cmd = rra_pkg::CMD_ALLOC;
          else if (r < 70) begin
            cmd = rra_pkg::CMD_RELEASE;
            rid = ledger.pick_held_id();
          end else if (r < 80) begin
            cmd = rra_pkg::CMD_RELEASE;
            rid = 16'(ID_BASE + $urandom_range(0, NUM_IDS - 1));
          end else if (r < 95) cmd = rra_pkg::CMD_FINISH;
          else cmd = rra_pkg::CMD_RELEASE;
        end else if (mode <= 17) begin
          if (r < 70) begin
            cmd = rra_pkg::CMD_RELEASE;
            rid = ledger.pick_held_id();
          end else if (r < 85) cmd = rra_pkg::CMD_FINISH;
          else cmd = rra_pkg::CMD_ALLOC;
        end else begin
          cmd = rra_pkg::cmd_e'($urandom_range(0, 3));
          if (r < 50) rid = 16'($urandom_range(0, ID_BASE + NUM_IDS));
        end
        issue(cmd, rid);
        sent++;
      end
      if ((!paused && sent >= RANDOM_BEATS / 2) || $urandom_range(0, 7) == 0) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    // wind down: collect remaining answers, then allow a full search time
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (NUM_IDS + 8) @(posedge clk_i);
    if (ledger.mismatch_cnt == 0 && ledger.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rra_pkg.sv
rtl/rra_cell.sv
rtl/round_robin_id_allocator.sv
dv/tb_round_robin_id_allocator.sv
